FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an implication on every clock, quiet during reset
`define RMQ_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("rmq assertion failed");

// check an implication in the next cycle, quiet during reset
`define RMQ_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("rmq assertion failed");

`endif

FILE: rtl/core/rmq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int IN_W          = 16;
  localparam int OUT_W         = 16;
  localparam int N_IN          = 9;
  localparam int N_OUT         = 4;

  // signed width of one diagonal term before clamping
  function automatic int term_width(input int f);
    return ((f > 15) ? f : 15) + 3;
  endfunction

  // quotient width of t * 4^(F+1) / total
  function automatic int quot_width(input int f);
    return 2 * f + 3;
  endfunction

  // integer root width
  function automatic int root_width(input int f);
    return f + 2;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/rmq_root.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rmq_root #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int NS        = 3 * rmq_pkg::FRAC_BITS_DEF + 7
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic [NS-1:0]                           en,
  input  wire logic [NS-1:0]                           vld,
  input  wire logic [rmq_pkg::term_width(FRAC_BITS)-2:0] t,
  input  wire logic [rmq_pkg::term_width(FRAC_BITS):0]   total,
  output logic      [rmq_pkg::root_width(FRAC_BITS)-1:0] root
);
  import rmq_pkg::*;

  localparam int TU   = term_width(FRAC_BITS) - 1;
  localparam int TOTW = TU + 2;
  localparam int QW   = quot_width(FRAC_BITS);
  localparam int SW   = root_width(FRAC_BITS);
  localparam int RW   = QW + 1;

  logic [TOTW-1:0] drem [QW+1];
  logic [TOTW-1:0] dtot [QW+1];
  logic [QW-1:0]   dq   [QW+1];
  logic [RW-1:0]   srem [SW+1];
  logic [SW-1:0]   sq   [SW+1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      drem[0] <= TOTW'(t);
      dtot[0] <= total;
      dq[0]   <= '0;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [TOTW:0] trial;
    logic          ge;
    always_comb begin
      trial = (k == 1) ? {1'b0, drem[k-1]} : {drem[k-1], 1'b0};
      ge    = trial >= {1'b0, dtot[k-1]};
    end
    always_ff @(posedge clk) begin
      if (en[k]) begin
        drem[k] <= ge ? TOTW'(trial - {1'b0, dtot[k-1]}) : trial[TOTW-1:0];
        dtot[k] <= dtot[k-1];
        dq[k]   <= {dq[k-1][QW-2:0], ge};
      end
    end
  end

  assign srem[0] = RW'(dq[QW]);
  assign sq[0]   = '0;

  for (genvar j = 1; j <= SW; j++) begin : g_sqrt
    localparam int B = SW - j;
    logic [RW-1:0] d;
    logic          ge;
    always_comb begin
      d  = (RW'(sq[j-1]) << (B + 1)) | (RW'(1) << (2 * B));
      ge = srem[j-1] >= d;
    end
    always_ff @(posedge clk) begin
      if (en[QW+j]) begin
        srem[j] <= ge ? srem[j-1] - d : srem[j-1];
        sq[j]   <= ge ? (sq[j-1] | (SW'(1) << B)) : sq[j-1];
      end
    end
  end

  assign root = sq[SW];

  `RMQ_ASSERT_IMP(a_div_rem, vld[QW], drem[QW] < dtot[QW])
  `RMQ_ASSERT_IMP(a_root_max, vld[QW+SW], sq[SW] <= (SW'(1) << (SW - 1)))

endmodule
`default_nettype wire

FILE: rtl/core/rotation_matrix_to_quaternion_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Throughput: one matrix per cycle; each stage stalls only when the next one is full.
// Depth set by the bit-per-stage divider (2*FRAC_BITS+3) and square root (FRAC_BITS+2).
// Reset: synchronous, active high; clears stage valid bits only.
module rotation_matrix_to_quaternion_core #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     s_axis_tvalid,
  output logic                                          s_axis_tready,
  // r11, r12, r13, r21, r22, r23, r31, r32, r33 (16 bits each)
  input  wire logic [rmq_pkg::N_IN*rmq_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                                          m_axis_tvalid,
  input  wire logic                                     m_axis_tready,
  // quat_w, quat_x, quat_y, quat_z (16 bits each)
  output logic      [rmq_pkg::N_OUT*rmq_pkg::OUT_W-1:0] m_axis_tdata
);
  import rmq_pkg::*;

  localparam int TW   = term_width(FRAC_BITS);
  localparam int TU   = TW - 1;
  localparam int TOTW = TU + 2;
  localparam int QW   = quot_width(FRAC_BITS);
  localparam int SW   = root_width(FRAC_BITS);
  localparam int NS   = QW + SW + 2;
  localparam int MW   = (SW > OUT_W) ? SW : OUT_W;

  logic [NS-1:0] vld;
  logic [NS:0]   rdy;
  logic [NS-1:0] en;

  always_comb begin
    rdy[NS] = m_axis_tready;
    for (int i = NS - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign en            = rdy[NS-1:0];
  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= s_axis_tvalid;
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) vld[i] <= vld[i-1];
      end
    end
  end

  logic signed [IN_W-1:0] r [N_IN];
  logic signed [TW-1:0]   e11, e22, e33, one;
  logic signed [TW-1:0]   ts [N_OUT];
  logic [TU-1:0]          tc [N_OUT];
  logic [TOTW-1:0]        tot_c;
  logic [1:0]             big;
  logic                   d32, d13, d21, s12, s13, s23;
  logic signed [IN_W:0]   sum12, sum13, sum23;
  logic [N_OUT-1:0]       pos_c;

  always_comb begin
    for (int i = 0; i < N_IN; i++) begin
      r[i] = s_axis_tdata[i*IN_W +: IN_W];
    end
    e11   = TW'(r[0]);
    e22   = TW'(r[4]);
    e33   = TW'(r[8]);
    one   = TW'(1) <<< FRAC_BITS;
    ts[0] = one + e11 + e22 + e33;
    ts[1] = one + e11 - e22 - e33;
    ts[2] = one - e11 + e22 - e33;
    ts[3] = one - e11 - e22 + e33;
    tot_c = '0;
    for (int i = 0; i < N_OUT; i++) begin
      tc[i] = ts[i][TW-1] ? '0 : ts[i][TU-1:0];
      tot_c = tot_c + TOTW'(tc[i]);
    end
    big = 2'd0;
    for (int i = 1; i < N_OUT; i++) begin
      if (tc[i] > tc[big]) big = 2'(i);
    end
    d32   = r[7] >= r[5];
    d13   = r[2] >= r[6];
    d21   = r[3] >= r[1];
    sum12 = (IN_W+1)'(r[3]) + (IN_W+1)'(r[1]);
    sum13 = (IN_W+1)'(r[2]) + (IN_W+1)'(r[6]);
    sum23 = (IN_W+1)'(r[7]) + (IN_W+1)'(r[5]);
    s12   = !sum12[IN_W];
    s13   = !sum13[IN_W];
    s23   = !sum23[IN_W];
    case (big)
      2'd0:    pos_c = {d21, d13, d32, 1'b1};
      2'd1:    pos_c = {s13, s12, 1'b1, d32};
      2'd2:    pos_c = {s23, 1'b1, s12, d13};
      default: pos_c = {1'b1, s23, s13, d21};
    endcase
  end

  logic [N_OUT-1:0] pos [NS-1];

  always_ff @(posedge clk) begin
    if (en[0]) pos[0] <= pos_c;
    for (int i = 1; i < NS - 1; i++) begin
      if (en[i]) pos[i] <= pos[i-1];
    end
  end

  logic [SW-1:0] root [N_OUT];

  for (genvar l = 0; l < N_OUT; l++) begin : g_lane
    rmq_root #(
      .FRAC_BITS (FRAC_BITS),
      .NS        (NS)
    ) u_root (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .vld   (vld),
      .t     (tc[l]),
      .total (tot_c),
      .root  (root[l])
    );
  end

  logic [OUT_W-1:0] q_next [N_OUT];

  always_comb begin
    logic [SW:0]    m;
    logic [MW-1:0]  mx;
    logic [OUT_W-1:0] mag;
    for (int l = 0; l < N_OUT; l++) begin
      m   = ((SW+1)'(root[l]) + (SW+1)'(1)) >> 1;
      mx  = MW'(m[SW-1:0]);
      mag = (mx > MW'(32767)) ? OUT_W'(32767) : mx[OUT_W-1:0];
      q_next[l] = pos[NS-2][l] ? mag : OUT_W'(-mag);
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      for (int l = 0; l < N_OUT; l++) begin
        m_axis_tdata[l*OUT_W +: OUT_W] <= q_next[l];
      end
    end
  end

  `RMQ_ASSERT_IMP(a_rdy_empty, !vld[0], s_axis_tready)
  `RMQ_ASSERT_IMP(a_big_pos, s_axis_tvalid && s_axis_tready, pos_c[big])
  `RMQ_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                  $stable(m_axis_tdata) && vld[NS-1])

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rmq_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LIMIT = 400000;

  typedef struct {
    bit                      drain;
    int                      idle_pct;
    int                      stall_pct;
    logic [N_IN*IN_W-1:0]    mat;
  } matrix_item_t;

  logic                      clk;
  logic                      rst;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [N_IN*IN_W-1:0]      s_axis_tdata;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [N_OUT*OUT_W-1:0]    m_axis_tdata;

  matrix_item_t              pending_mats[$];
  logic [N_OUT*OUT_W-1:0]    expected_quats[$];
  int                        stall_pct;
  int                        errors;
  int                        cycles;

  rotation_matrix_to_quaternion_core DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  function automatic logic [N_OUT*OUT_W-1:0] quat_of(logic [N_IN*IN_W-1:0] m);
    longint r[9];
    longint t[4];
    longint one;
    longint unsigned total;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned md;
    longint unsigned k;
    int big;
    bit pos[4];
    bit d32, d13, d21, s12, s13, s23;
    logic signed [15:0] v;
    logic [N_OUT*OUT_W-1:0] q;
    for (int i = 0; i < 9; i++) r[i] = longint'($signed(m[16*i +: 16]));
    one = longint'(1) << FB;
    d32 = r[7] >= r[5];
    d13 = r[2] >= r[6];
    d21 = r[3] >= r[1];
    s12 = (r[3] + r[1]) >= 0;
    s13 = (r[2] + r[6]) >= 0;
    s23 = (r[7] + r[5]) >= 0;
    t[0] = one + r[0] + r[4] + r[8];
    t[1] = one + r[0] - r[4] - r[8];
    t[2] = one - r[0] + r[4] - r[8];
    t[3] = one - r[0] - r[4] + r[8];
    total = 0;
    for (int i = 0; i < 4; i++) begin
      if (t[i] < 0) t[i] = 0;
      total += longint'(t[i]);
    end
    big = 0;
    for (int i = 1; i < 4; i++) if (t[i] > t[big]) big = i;
    case (big)
      0: begin pos[0] = 1; pos[1] = d32; pos[2] = d13; pos[3] = d21; end
      1: begin pos[0] = d32; pos[1] = 1; pos[2] = s12; pos[3] = s13; end
      2: begin pos[0] = d13; pos[1] = s12; pos[2] = 1; pos[3] = s23; end
      default: begin pos[0] = d21; pos[1] = s13; pos[2] = s23; pos[3] = 1; end
    endcase
    for (int i = 0; i < 4; i++) begin
      lo = 0;
      hi = 64'd1 << FB;
      while (lo < hi) begin
        md = (lo + hi + 1) >> 1;
        k = 2 * md - 1;
        if (k * k * total <= longint'(t[i]) * (64'd1 << (2 * FB + 2))) lo = md;
        else hi = md - 1;
      end
      if (lo > 32767) lo = 32767;
      v = pos[i] ? 16'(lo) : -16'(lo);
      q[16*i +: 16] = v;
    end
    return q;
  endfunction

  function automatic logic [15:0] to_q14(real x);
    int n;
    n = $rtoi(x * (1 << FB) + ((x >= 0.0) ? 0.5 : -0.5));
    if (n > 16384) n = 16384;
    if (n < -16384) n = -16384;
    return 16'(n);
  endfunction

  function automatic logic [N_IN*IN_W-1:0] random_rotation();
    real w, x, y, z, n;
    logic [N_IN*IN_W-1:0] m;
    w = real'(int'($urandom_range(0, 20000)) - 10000);
    x = real'(int'($urandom_range(0, 20000)) - 10000);
    y = real'(int'($urandom_range(0, 20000)) - 10000);
    z = real'(int'($urandom_range(0, 20000)) - 10000);
    case ($urandom_range(0, 5))
      0: w = 0.0;
      1: x = 0.0;
      2: begin y = 0.0; z = 0.0; end
      default: ;
    endcase
    n = $sqrt(w * w + x * x + y * y + z * z);
    if (n < 1.0) begin w = 1.0; n = 1.0; end
    w /= n; x /= n; y /= n; z /= n;
    m[0*16 +: 16] = to_q14(1.0 - 2.0 * (y * y + z * z));
    m[1*16 +: 16] = to_q14(2.0 * (x * y - w * z));
    m[2*16 +: 16] = to_q14(2.0 * (x * z + w * y));
    m[3*16 +: 16] = to_q14(2.0 * (x * y + w * z));
    m[4*16 +: 16] = to_q14(1.0 - 2.0 * (x * x + z * z));
    m[5*16 +: 16] = to_q14(2.0 * (y * z - w * x));
    m[6*16 +: 16] = to_q14(2.0 * (x * z - w * y));
    m[7*16 +: 16] = to_q14(2.0 * (y * z + w * x));
    m[8*16 +: 16] = to_q14(1.0 - 2.0 * (x * x + y * y));
    return m;
  endfunction

  function automatic logic [N_IN*IN_W-1:0] diag(int a, int b, int c, int o);
    logic [N_IN*IN_W-1:0] m;
    for (int i = 0; i < 9; i++) m[16*i +: 16] = 16'(o);
    m[0 +: 16] = 16'(a);
    m[64 +: 16] = 16'(b);
    m[128 +: 16] = 16'(c);
    return m;
  endfunction

  task automatic add_mat(logic [N_IN*IN_W-1:0] m, int ip, int sp);
    matrix_item_t it;
    it.drain = 0;
    it.idle_pct = ip;
    it.stall_pct = sp;
    it.mat = m;
    pending_mats.push_back(it);
  endtask

  task automatic add_drain();
    matrix_item_t it;
    it.drain = 1;
    it.idle_pct = 0;
    it.stall_pct = 0;
    it.mat = '0;
    pending_mats.push_back(it);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    logic [N_IN*IN_W-1:0] m;
    int ip, sp, sel;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    m_axis_tready = 0;
    stall_pct = 0;
    errors = 0;
    repeat (4) @(posedge clk);
    rst <= 0;

    add_mat(diag(16384, 16384, 16384, 0), 0, 0);
    add_mat(diag(16384, -16384, -16384, 0), 0, 0);
    add_mat(diag(-16384, 16384, -16384, 0), 0, 0);
    add_mat(diag(-16384, -16384, 16384, 0), 0, 0);
    add_mat(diag(0, 0, 0, 0), 0, 0);
    add_mat(diag(0, 0, 0, 16384), 0, 0);
    add_mat(diag(0, 0, 0, -16384), 0, 0);
    add_mat(diag(-16384, -16384, -16384, 0), 0, 0);
    add_mat(diag(-32768, -32768, -32768, -32768), 0, 0);
    add_mat(diag(32767, 32767, 32767, 32767), 0, 0);
    add_mat(diag(32767, -32768, -32768, 32767), 0, 0);
    add_mat(diag(-32768, 32767, 32767, -32768), 0, 0);
    add_mat(diag(0, 0, -16384, 0), 0, 0);
    add_mat(diag(16384, 0, 0, 0), 0, 0);
    add_mat(diag(0, 16384, 0, 0), 0, 0);
    for (int i = 0; i < 8; i++) begin
      m = diag(8192 * (i % 3) - 8192, 8192 - 4096 * (i % 2), 0, 0);
      for (int j = 0; j < 9; j++)
        if (j != 0 && j != 4 && j != 8)
          m[16*j +: 16] = ($urandom_range(0, 1)) ? 16'(i * 97) : -16'(i * 97);
      add_mat(m, 0, 0);
    end
    add_drain();

    for (int ph = 0; ph < 4; ph++) begin
      ip = (ph == 1 || ph == 3) ? ((ph == 3) ? 9 : 58) : 0;
      sp = (ph == 2 || ph == 3) ? ((ph == 3) ? 9 : 58) : 0;
      for (int n = 0; n < 282; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 65) m = random_rotation();
        else if (sel < 85)
          for (int j = 0; j < 9; j++) m[16*j +: 16] = 16'(int'($urandom_range(0, 32768)) - 16384);
        else
          for (int j = 0; j < 9; j++) m[16*j +: 16] = 16'($urandom);
        add_mat(m, ip, sp);
      end
      add_drain();
    end

    wait (pending_mats.size() == 0);
    @(posedge clk);
    while (s_axis_tvalid) @(posedge clk);
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (errors == 0) $display("rotation_matrix_to_quaternion_core test passed");
    else $display("rotation_matrix_to_quaternion_core test failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) expected_quats.push_back(quat_of(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_mats.size() != 0 && pending_mats[0].drain) begin
          s_axis_tvalid <= 0;
          if (expected_quats.size() == 0 && !(s_axis_tvalid && s_axis_tready))
            void'(pending_mats.pop_front());
        end else if (pending_mats.size() != 0 &&
                     $urandom_range(0, 99) >= pending_mats[0].idle_pct) begin
          s_axis_tvalid <= 1;
          s_axis_tdata <= pending_mats[0].mat;
          stall_pct <= pending_mats[0].stall_pct;
          void'(pending_mats.pop_front());
        end else begin
          s_axis_tvalid <= 0;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [N_OUT*OUT_W-1:0] exp_q;
    if (!rst) begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_quats.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          errors++;
        end else begin
          exp_q = expected_quats.pop_front();
          for (int i = 0; i < N_OUT; i++)
            if (m_axis_tdata[16*i +: 16] !== exp_q[16*i +: 16]) begin
              $display("%0t: component %0d expected %0d actual %0d", $time, i,
                       $signed(exp_q[16*i +: 16]), $signed(m_axis_tdata[16*i +: 16]));
              errors++;
            end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("rotation_matrix_to_quaternion_core test failed");
      $finish;
    end
  end

  initial cycles = 0;

endmodule
